>>> rtl/gss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gss_pkg
// Shared types, codes and constants of the Gauss-Seidel solver.
// ----------------------------------------------------------------------------
package gss_pkg;

    localparam int MaxSize  = 16;
    localparam int IdxW     = $clog2(MaxSize);
    localparam int CoefAw   = 2 * IdxW;
    localparam int CoefDep  = MaxSize * MaxSize;
    localparam int SizeW    = 5;
    localparam int TolW     = 31;
    localparam int SweepW   = 16;
    localparam int PaddrW   = 4;

    localparam logic [1:0] REQ_LOAD_A = 2'd0;
    localparam logic [1:0] REQ_LOAD_B = 2'd1;
    localparam logic [1:0] REQ_START  = 2'd2;

    localparam logic [1:0] ST_CONVERGED = 2'd0;
    localparam logic [1:0] ST_DIVERGED  = 2'd1;
    localparam logic [1:0] ST_LIMIT     = 2'd2;
    localparam logic [1:0] ST_ZERO_DIAG = 2'd3;

    localparam logic [PaddrW-1:0] ADDR_SIZE  = 4'h0;
    localparam logic [PaddrW-1:0] ADDR_TOL   = 4'h4;
    localparam logic [PaddrW-1:0] ADDR_LIMIT = 4'h8;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [3:0]        row_index;
        logic [3:0]        col_index;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic [3:0]         elem_index;
        logic signed [31:0] solution;
        logic               is_last;
        logic [1:0]         status;
        logic [15:0]        sweeps_done;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic            clr_x;      // zero solution store and previous sweep change
        logic            row_init;   // load accumulator with b[i] << 16
        logic            mac;        // accumulator -= product
        logic            div_start;
        logic            x_write;    // write quotient into x[i], update max
        logic            sweep_clr;  // clear per-sweep max change
        logic            sweep_end;  // apply stop rule bookkeeping
        logic [IdxW-1:0] row;
        logic [IdxW-1:0] col;
        logic            diag_rd;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic div_done;
        logic diag_zero;
        logic diverged;
        logic converged;
    } t_dp_sts;

endpackage

>>> rtl/gss_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gss_ram
// Generic single-port-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gss_ram #(
    parameter int Width = 32,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> rtl/gss_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gss_div
// Restoring divider, one quotient bit a cycle: signed Q32.32 by signed Q16.16,
// truncated toward zero and saturated to 32 bits.
// ----------------------------------------------------------------------------
module gss_div import gss_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_num,
    input  logic signed [31:0] i_den,
    output logic               o_done,
    output logic [31:0]        o_quot
);

    logic [63:0] r_rem;      // numerator bits shifted out
    logic [64:0] r_part;     // partial remainder
    logic [63:0] r_q;
    logic [31:0] r_den;
    logic        r_neg;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic [64:0] w_trial;
    logic [64:0] w_shift;
    logic [63:0] w_mag_n;
    logic        w_big;

    assign w_mag_n = i_num[63] ? (64'd0 - i_num) : i_num;
    assign w_shift = {r_part[63:0], r_rem[63]};
    assign w_trial = w_shift - {33'd0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd0;
                r_rem  <= w_mag_n;
                r_part <= '0;
                r_q    <= '0;
                r_den  <= i_den[31] ? (32'd0 - i_den) : i_den;
                r_neg  <= i_num[63] ^ i_den[31];
            end else if (r_busy) begin
                r_rem <= {r_rem[62:0], 1'b0};
                if (!w_trial[64]) begin
                    r_part <= w_trial;
                    r_q    <= {r_q[62:0], 1'b1};
                end else begin
                    r_part <= w_shift;
                    r_q    <= {r_q[62:0], 1'b0};
                end
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign w_big = |r_q[63:31];
    always_comb begin
        if (r_neg) begin
            o_quot = (w_big) ? 32'h8000_0000 : (32'd0 - r_q[31:0]);
        end else begin
            o_quot = (w_big) ? 32'h7FFF_FFFF : r_q[31:0];
        end
    end

endmodule

>>> rtl/gss_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gss_datapath
// Coefficient and right-hand memories, solution registers, multiply and
// saturating accumulate, divider and change tracking.
// ----------------------------------------------------------------------------
module gss_datapath import gss_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_in_item             i_item,
    input  logic                 i_load,
    input  t_dp_cmd              i_cmd,
    input  logic [TolW-1:0]      i_tol,
    input  logic [IdxW-1:0]      i_out_idx,
    output t_dp_sts              o_sts,
    output logic signed [31:0]   o_x
);

    logic                 w_a_we;
    logic                 w_b_we;
    logic [31:0]          w_a_rd;
    logic [31:0]          w_b_rd;
    logic signed [31:0]   r_x [MaxSize];
    logic signed [63:0]   r_prod;
    logic                 r_prod_v;
    logic signed [63:0]   r_acc;
    logic signed [64:0]   w_diff;
    logic signed [31:0]   r_diag;
    logic [31:0]          w_quot;
    logic                 w_div_done;
    logic signed [32:0]   w_chg_s;
    logic [31:0]          w_chg;
    logic [31:0]          r_cur;
    logic [31:0]          r_prev;
    logic                 r_mac_d;
    logic [IdxW-1:0]      r_col_d;
    logic signed [63:0]   w_prod;

    assign w_a_we = i_load && (i_item.req_type == REQ_LOAD_A);
    assign w_b_we = i_load && (i_item.req_type == REQ_LOAD_B);

    gss_ram #(.Width(32), .Depth(CoefDep)) u_coef (
        .i_clk  (i_clk),
        .i_we   (w_a_we),
        .i_waddr({i_item.row_index[IdxW-1:0], i_item.col_index[IdxW-1:0]}),
        .i_wdata(i_item.value),
        .i_raddr({i_cmd.row, i_cmd.col}),
        .o_rdata(w_a_rd)
    );

    gss_ram #(.Width(32), .Depth(MaxSize)) u_rhs (
        .i_clk  (i_clk),
        .i_we   (w_b_we),
        .i_waddr(i_item.row_index[IdxW-1:0]),
        .i_wdata(i_item.value),
        .i_raddr(i_cmd.row),
        .o_rdata(w_b_rd)
    );

    gss_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_cmd.div_start),
        .i_num  (r_acc),
        .i_den  (r_diag),
        .o_done (w_div_done),
        .o_quot (w_quot)
    );

    // x index of the product is the column read in the previous cycle
    always_ff @(posedge i_clk) begin
        r_col_d <= i_cmd.col;
    end
    assign w_prod = $signed(w_a_rd) * r_x[r_col_d];

    // memory read data is registered in the RAM; the product is registered once more
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mac_d  <= 1'b0;
            r_prod_v <= 1'b0;
        end else begin
            r_mac_d  <= i_cmd.mac;
            r_prod_v <= r_mac_d;
        end
        if (r_mac_d) begin
            r_prod <= w_prod;
        end
        if (i_cmd.diag_rd) begin
            r_diag <= w_a_rd;
        end
    end

    assign w_diff = {r_acc[63], r_acc} - {r_prod[63], r_prod};

    always_ff @(posedge i_clk) begin
        if (i_cmd.row_init) begin
            r_acc <= {{16{w_b_rd[31]}}, w_b_rd, 16'd0};
        end else if (r_prod_v) begin
            if (w_diff[64] != w_diff[63]) begin
                r_acc <= w_diff[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
            end else begin
                r_acc <= w_diff[63:0];
            end
        end
    end

    assign w_chg_s = {w_quot[31], w_quot} - {r_x[i_cmd.row][31], r_x[i_cmd.row]};
    assign w_chg   = w_chg_s[32] ? 32'(33'd0 - w_chg_s) : w_chg_s[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur  <= '0;
            r_prev <= '0;
            for (int k = 0; k < MaxSize; k++) begin
                r_x[k] <= '0;
            end
        end else begin
            if (i_cmd.clr_x) begin
                for (int k = 0; k < MaxSize; k++) begin
                    r_x[k] <= '0;
                end
                r_prev <= '0;
            end
            if (i_cmd.sweep_clr) begin
                r_cur <= '0;
            end
            if (i_cmd.x_write) begin
                r_x[i_cmd.row] <= w_quot;
                if (w_chg > r_cur) begin
                    r_cur <= w_chg;
                end
            end
            if (i_cmd.sweep_end && !o_sts.diverged) begin
                r_prev <= r_cur;
            end
        end
    end

    assign o_sts.div_done  = w_div_done;
    assign o_sts.diag_zero = (w_a_rd == 32'd0);
    assign o_sts.diverged  = (r_prev != '0) && (r_cur > r_prev);
    assign o_sts.converged = (r_cur <= {1'b0, i_tol});
    assign o_x = r_x[i_out_idx];

endmodule

>>> rtl/gss_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gss_ctrl
// Sequencer: diagonal check, row-by-row sweeps, stop rule and result beats.
// ----------------------------------------------------------------------------
module gss_ctrl import gss_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SizeW-1:0]  i_size,
    input  logic [SweepW-1:0] i_limit,
    input  t_dp_sts           i_sts,
    output t_dp_cmd           o_cmd,
    output logic              o_busy,
    output logic              o_strobe,
    output logic [IdxW-1:0]   o_idx,
    output logic              o_last,
    output logic [1:0]        o_status,
    output logic [SweepW-1:0] o_sweeps,
    output logic              o_zero
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DCHK   = 4'd1;
    localparam logic [3:0] S_DWAIT  = 4'd2;
    localparam logic [3:0] S_RINIT  = 4'd3;
    localparam logic [3:0] S_RDIAG  = 4'd4;
    localparam logic [3:0] S_MAC    = 4'd5;
    localparam logic [3:0] S_DRAIN  = 4'd6;
    localparam logic [3:0] S_DIV    = 4'd7;
    localparam logic [3:0] S_DWR    = 4'd8;
    localparam logic [3:0] S_STOP   = 4'd9;
    localparam logic [3:0] S_EMIT   = 4'd10;

    logic [3:0]        r_state, n_state;
    logic [IdxW-1:0]   r_row, n_row;
    logic [IdxW-1:0]   r_col, n_col;
    logic [1:0]        r_drain, n_drain;
    logic [IdxW-1:0]   r_nm1, n_nm1;
    logic [SweepW-1:0] r_lim, n_lim;
    logic [SweepW-1:0] r_sweeps, n_sweeps;
    logic [1:0]        r_status, n_status;
    logic              r_zero, n_zero;
    logic [SweepW-1:0] w_sw1;

    assign w_sw1 = r_sweeps + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_row    <= '0;
            r_col    <= '0;
            r_drain  <= '0;
            r_nm1    <= '0;
            r_lim    <= '0;
            r_sweeps <= '0;
            r_status <= ST_CONVERGED;
            r_zero   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_row    <= n_row;
            r_col    <= n_col;
            r_drain  <= n_drain;
            r_nm1    <= n_nm1;
            r_lim    <= n_lim;
            r_sweeps <= n_sweeps;
            r_status <= n_status;
            r_zero   <= n_zero;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_row    = r_row;
        n_col    = r_col;
        n_drain  = r_drain;
        n_nm1    = r_nm1;
        n_lim    = r_lim;
        n_sweeps = r_sweeps;
        n_status = r_status;
        n_zero   = r_zero;
        o_cmd    = '0;
        o_cmd.row = r_row;
        o_cmd.col = r_col;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_size == '0) begin
                        n_nm1 = '0;
                    end else if (i_size > SizeW'(MaxSize)) begin
                        n_nm1 = IdxW'(MaxSize - 1);
                    end else begin
                        n_nm1 = IdxW'(i_size - 1'b1);
                    end
                    n_lim    = (i_limit == '0) ? SweepW'(1) : i_limit;
                    n_sweeps = '0;
                    n_zero   = 1'b0;
                    n_row    = '0;
                    n_col    = '0;
                    o_cmd.clr_x = 1'b1;
                    n_state  = S_DCHK;
                end
            end
            // read A[row][row], check it next cycle
            S_DCHK: begin
                o_cmd.col = r_row;
                n_state   = S_DWAIT;
            end
            S_DWAIT: begin
                if (i_sts.diag_zero) begin
                    n_zero   = 1'b1;
                    n_status = ST_ZERO_DIAG;
                    n_row    = '0;
                    n_state  = S_EMIT;
                end else if (r_row == r_nm1) begin
                    n_row   = '0;
                    n_state = S_RINIT;
                    o_cmd.sweep_clr = 1'b1;
                end else begin
                    n_row   = r_row + 1'b1;
                    n_state = S_DCHK;
                end
            end
            // b read address presented; also read diagonal
            S_RINIT: begin
                o_cmd.col = r_row;
                n_state   = S_RDIAG;
            end
            S_RDIAG: begin
                o_cmd.row_init = 1'b1;
                o_cmd.diag_rd  = 1'b1;
                n_col   = '0;
                n_state = S_MAC;
            end
            S_MAC: begin
                o_cmd.mac = (r_col != r_row);
                if (r_col == r_nm1) begin
                    n_drain = 2'd0;
                    n_state = S_DRAIN;
                end else begin
                    n_col = r_col + 1'b1;
                end
            end
            S_DRAIN: begin
                n_drain = r_drain + 1'b1;
                if (r_drain == 2'd2) begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_DWR;
                end
            end
            S_DWR: begin
                o_cmd.x_write = 1'b1;
                if (r_row == r_nm1) begin
                    n_sweeps = w_sw1;
                    n_state  = S_STOP;
                end else begin
                    n_row   = r_row + 1'b1;
                    n_state = S_RINIT;
                end
            end
            S_STOP: begin
                o_cmd.sweep_end = 1'b1;
                n_row = '0;
                if (i_sts.diverged) begin
                    n_status = ST_DIVERGED;
                    n_state  = S_EMIT;
                end else if (i_sts.converged) begin
                    n_status = ST_CONVERGED;
                    n_state  = S_EMIT;
                end else if (r_sweeps >= r_lim) begin
                    n_status = ST_LIMIT;
                    n_state  = S_EMIT;
                end else begin
                    o_cmd.sweep_clr = 1'b1;
                    n_state = S_RINIT;
                end
            end
            S_EMIT: begin
                if (r_row == r_nm1) begin
                    n_state = S_IDLE;
                end else begin
                    n_row = r_row + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = (r_state == S_EMIT);
    assign o_idx    = r_row;
    assign o_last   = (r_row == r_nm1);
    assign o_status = r_status;
    assign o_sweeps = r_sweeps;
    assign o_zero   = r_zero;

endmodule

>>> rtl/gauss_seidel_solver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gauss_seidel_solver
// Gauss-Seidel solver for A x = b in signed Q16.16 with 64-bit accumulation.
// Load beats are accepted while not busy. A start beat of size n holds busy
// through a diagonal check of each row (read, then test) and the sweeps: per
// row two read states, a MAC state per column, a drain, a bit-serial divide
// and one write-back, one stop check per sweep, then the n result beats on
// consecutive cycles. A zero diagonal skips the sweeps. The receiver cannot
// stall. Synchronous active-low reset restores register defaults and zeroes
// the solution; A and b are undefined until loaded.
// ----------------------------------------------------------------------------
module gauss_seidel_solver import gss_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_in_item          i_item,
    output logic              o_strobe,
    output t_out_item         o_item,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [PaddrW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [SizeW-1:0]  r_size;
    logic [TolW-1:0]   r_tol;
    logic [SweepW-1:0] r_limit;
    logic              w_acc;
    logic              w_load;
    logic              w_start;
    t_dp_cmd           w_cmd;
    t_dp_sts           w_sts;
    logic              w_busy;
    logic              w_strobe;
    logic [IdxW-1:0]   w_idx;
    logic              w_last;
    logic [1:0]        w_status;
    logic [SweepW-1:0] w_sweeps;
    logic              w_zero;
    logic signed [31:0] w_x;

    assign pready = 1'b1;
    assign busy   = w_busy;
    assign w_acc  = start && !w_busy;
    assign w_load = w_acc && (i_item.req_type == REQ_LOAD_A ||
                              i_item.req_type == REQ_LOAD_B);
    assign w_start = w_acc && (i_item.req_type == REQ_START);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size  <= SizeW'(16);
            r_tol   <= TolW'(66);
            r_limit <= SweepW'(1000);
        end else if (psel && penable && pwrite) begin
            unique case (paddr)
                ADDR_SIZE:  r_size  <= pwdata[SizeW-1:0];
                ADDR_TOL:   r_tol   <= pwdata[TolW-1:0];
                ADDR_LIMIT: r_limit <= pwdata[SweepW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr)
            ADDR_SIZE:  prdata = {27'd0, r_size};
            ADDR_TOL:   prdata = {1'b0, r_tol};
            ADDR_LIMIT: prdata = {16'd0, r_limit};
            default:    prdata = '0;
        endcase
    end

    gss_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_size  (r_size),
        .i_limit (r_limit),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (w_busy),
        .o_strobe(w_strobe),
        .o_idx   (w_idx),
        .o_last  (w_last),
        .o_status(w_status),
        .o_sweeps(w_sweeps),
        .o_zero  (w_zero)
    );

    gss_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_load   (w_load),
        .i_cmd    (w_cmd),
        .i_tol    (r_tol),
        .i_out_idx(w_idx),
        .o_sts    (w_sts),
        .o_x      (w_x)
    );

    assign o_strobe           = w_strobe;
    assign o_item.elem_index  = w_idx;
    assign o_item.solution    = w_zero ? 32'sd0 : w_x;
    assign o_item.is_last     = w_last;
    assign o_item.status      = w_status;
    assign o_item.sweeps_done = w_sweeps;

    a_no_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy) else $error("result beat while idle");
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_item.is_last) |=> !o_strobe) else $error("beat after last");
    a_zero_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_item.status == ST_ZERO_DIAG) |-> o_item.sweeps_done == 16'd0)
        else $error("sweeps on zero diagonal");

endmodule

>>> tb/tb_gauss_seidel_solver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gauss_seidel_solver
// Self-checking bench for the Gauss-Seidel solver. Loads matrix and
// right-hand-side beats, fires solves under a range of size, tolerance and
// sweep-limit settings, and checks every solution beat against a bit-true
// Q16.16 solver model held in the scoreboard.
// ----------------------------------------------------------------------------
module tb_gauss_seidel_solver;
    import gss_pkg::*;

    class solver_scoreboard;
        bit signed [31:0] coeff [CoefDep];
        bit signed [31:0] rhs [MaxSize];
        bit signed [31:0] x [MaxSize];
        int unsigned size_reg = 16;
        int unsigned tol_reg = 66;
        int unsigned limit_reg = 1000;
        t_out_item expected_solutions [$];
        int unsigned mismatches, beats_in, results_out;
        int unsigned status_seen [4];

        function void write_register(logic [PaddrW-1:0] addr, logic [31:0] data);
            case (addr)
                ADDR_SIZE:  size_reg = data[SizeW-1:0];
                ADDR_TOL:   tol_reg = data[TolW-1:0];
                ADDR_LIMIT: limit_reg = data[SweepW-1:0];
                default: ;
            endcase
        endfunction

        function longint sub_sat(longint acc, longint p);
            longint lo, hi;
            lo = 64'sh8000_0000_0000_0000;
            hi = 64'sh7fff_ffff_ffff_ffff;
            if (p > 0 && acc < lo + p) return lo;
            if (p < 0 && acc > hi + p) return hi;
            return acc - p;
        endfunction

        // Q32.32 / Q16.16, truncated toward zero, saturated to 32 bits
        function bit [31:0] div_q(longint acc, longint d);
            longint unsigned ma, md, q;
            bit neg;
            ma = acc < 0 ? 64'd0 - longint'(unsigned'(acc)) : unsigned'(acc);
            md = d < 0 ? 64'd0 - longint'(unsigned'(d)) : unsigned'(d);
            q = ma / md;
            neg = (acc < 0) != (d < 0);
            if (neg) return (q >= 64'h8000_0000) ? 32'h8000_0000 : 32'(64'd0 - q);
            return (q > 64'h7fff_ffff) ? 32'h7fff_ffff : q[31:0];
        endfunction

        function int unsigned sweep(int n);
            longint acc, diff;
            bit signed [31:0] oldv, newv;
            int unsigned maxd, ch;
            maxd = 0;
            for (int i = 0; i < n; i++) begin
                acc = longint'(rhs[i]) * 65536;
                oldv = x[i];
                for (int j = 0; j < n; j++)
                    if (j != i)
                        acc = sub_sat(acc, longint'(coeff[i*MaxSize+j]) * longint'(x[j]));
                newv = div_q(acc, longint'(coeff[i*MaxSize+i]));
                x[i] = newv;
                diff = longint'(newv) - longint'(oldv);
                ch = diff < 0 ? 32'(-diff) : 32'(diff);
                if (ch > maxd) maxd = ch;
            end
            return maxd;
        endfunction

        function void solve_system();
            int n;
            int unsigned lim, sweeps, cur, prev;
            bit zero_diag;
            logic [1:0] st;
            t_out_item r;
            n = size_reg == 0 ? 1 : (size_reg > MaxSize ? MaxSize : size_reg);
            lim = limit_reg == 0 ? 1 : limit_reg;
            foreach (x[i]) x[i] = 0;
            prev = 0;
            sweeps = 0;
            zero_diag = 0;
            for (int i = 0; i < n; i++)
                if (coeff[i*MaxSize+i] == 0) zero_diag = 1;
            if (zero_diag) begin
                st = ST_ZERO_DIAG;
            end else begin
                forever begin
                    cur = sweep(n);
                    sweeps++;
                    if (prev != 0 && cur > prev) begin
                        st = ST_DIVERGED;
                        break;
                    end
                    prev = cur;
                    if (cur <= tol_reg) begin
                        st = ST_CONVERGED;
                        break;
                    end
                    if (sweeps >= lim) begin
                        st = ST_LIMIT;
                        break;
                    end
                end
            end
            status_seen[st]++;
            for (int i = 0; i < n; i++) begin
                r.elem_index  = i[3:0];
                r.solution    = zero_diag ? 32'sd0 : x[i];
                r.is_last     = (i == n - 1);
                r.status      = st;
                r.sweeps_done = sweeps[15:0];
                expected_solutions.push_back(r);
            end
        endfunction

        function void note_beat(t_in_item it);
            beats_in++;
            case (it.req_type)
                REQ_LOAD_A: coeff[{it.row_index, it.col_index}] = it.value;
                REQ_LOAD_B: rhs[it.row_index] = it.value;
                REQ_START:  solve_system();
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_solutions.size();
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_result(t_out_item got);
            t_out_item e;
            results_out++;
            if (expected_solutions.size() == 0) begin
                report_mismatch($sformatf("unexpected result beat %p", got));
                return;
            end
            e = expected_solutions.pop_front();
            if (got.elem_index !== e.elem_index)
                report_mismatch($sformatf("elem_index %0d, want %0d", got.elem_index, e.elem_index));
            if (got.solution !== e.solution)
                report_mismatch($sformatf("x[%0d] %h, want %h", e.elem_index, got.solution,
                                          e.solution));
            if (got.is_last !== e.is_last)
                report_mismatch($sformatf("x[%0d] is_last %b, want %b", e.elem_index,
                                          got.is_last, e.is_last));
            if (got.status !== e.status)
                report_mismatch($sformatf("x[%0d] status %0d, want %0d", e.elem_index,
                                          got.status, e.status));
            if (got.sweeps_done !== e.sweeps_done)
                report_mismatch($sformatf("x[%0d] sweeps %0d, want %0d", e.elem_index,
                                          got.sweeps_done, e.sweeps_done));
        endtask
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    t_in_item          i_item = '0;
    logic              o_strobe;
    t_out_item         o_item;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [PaddrW-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    solver_scoreboard  sb;
    int                idle_pct;
    int                beats_sent;
    bit [CoefDep-1:0]  a_written;

    gauss_seidel_solver u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_strobe(o_strobe),
        .o_item  (o_item),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe === 1'b1 && sb != null)
            sb.check_result(o_item);
    end

    task send(logic [1:0] req, int row, int col, logic [31:0] val);
        t_in_item it;
        it.req_type  = req;
        it.row_index = row[3:0];
        it.col_index = col[3:0];
        it.value     = val;
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        sb.note_beat(it);
        beats_sent++;
        if (req == REQ_LOAD_A) a_written[{it.row_index, it.col_index}] = 1'b1;
    endtask

    // hold off until every solution beat is back and the block is idle
    task drain();
        start <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0 || busy);
        repeat (8) @(posedge i_clk);
    endtask

    task cfg_write(logic [PaddrW-1:0] addr, logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_register(addr, data);
    endtask

    task configure(logic [31:0] size_val, logic [31:0] tol, logic [31:0] lim);
        cfg_write(ADDR_SIZE, size_val);
        cfg_write(ADDR_TOL, tol);
        cfg_write(ADDR_LIMIT, lim);
    endtask

    // kind 0: diagonally dominant, 1: raw random, 2: dominant with a zero pivot
    task load_system(int n, int kind);
        int off_max, diag_mag, off;
        logic [31:0] val;
        off_max = $urandom_range(1, 'h20000);
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
                if (n < MaxSize || !a_written[i*MaxSize+j] || i == j
                        || $urandom_range(3) == 0) begin
                    if (kind == 1) begin
                        val = $urandom;
                    end else if (i == j) begin
                        diag_mag = n * off_max + $urandom_range(0, 'h4000_0000);
                        val = $urandom_range(1) ? -diag_mag : diag_mag;
                    end else begin
                        off = $urandom_range(0, 2 * off_max);
                        val = off - off_max;
                    end
                    send(REQ_LOAD_A, i, j, val);
                end
                if ($urandom_range(24) == 0)
                    send(2'd3, $urandom_range(15), $urandom_range(15), $urandom);
            end
            send(REQ_LOAD_B, i, $urandom_range(15), $urandom);
        end
        if (kind == 2) begin
            off = $urandom_range(n - 1);
            send(REQ_LOAD_A, off, off, 32'd0);
        end
    endtask

    initial begin
        int n, kind, target, rem;
        sb = new();
        idle_pct = 25;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // saturating quotients, one sweep allowed, loose tolerance
        configure(2, 32'h7fff_ffff, 0);
        send(REQ_LOAD_A, 0, 0, 32'h0004_0000);
        send(REQ_LOAD_A, 0, 1, 32'h8000_0000);
        send(REQ_LOAD_A, 1, 0, 32'h7fff_ffff);
        send(REQ_LOAD_A, 1, 1, 32'h0001_0000);
        send(REQ_LOAD_B, 0, 15, 32'h7fff_ffff);
        send(REQ_LOAD_B, 1, 0, 32'h8000_0000);
        send(REQ_LOAD_A, 15, 15, 32'hffff_ffff);
        send(REQ_LOAD_B, 15, 15, 32'h0000_0001);
        send(2'd3, 10, 5, 32'h5a5a_a5a5);
        send(REQ_START, 0, 0, 0);
        // exact fixed point: zero tolerance, widest sweep limit
        drain();
        configure(1, 0, 32'h0000_ffff);
        send(REQ_START, 3, 3, 32'hffff_ffff);
        // zero pivot on row 1
        drain();
        configure(2, 66, 1000);
        send(REQ_LOAD_A, 1, 1, 0);
        send(REQ_START, 0, 0, 0);
        // size zero behaves as one
        drain();
        configure(0, 66, 1000);
        send(REQ_START, 0, 0, 0);
        // growing change: diverges
        drain();
        configure(2, 66, 50);
        send(REQ_LOAD_A, 0, 0, 32'h0001_0000);
        send(REQ_LOAD_A, 0, 1, 32'h0002_0000);
        send(REQ_LOAD_A, 1, 0, 32'h0002_0000);
        send(REQ_LOAD_A, 1, 1, 32'h0001_0000);
        send(REQ_LOAD_B, 0, 0, 32'h0001_0000);
        send(REQ_LOAD_B, 1, 0, 32'h0001_0000);
        send(REQ_START, 0, 0, 0);

        target = beats_sent + 170;
        while (beats_sent < target) begin
            if (beats_sent < target - 113) idle_pct = 25;
            else if (beats_sent < target - 57) idle_pct = 56;
            else idle_pct = 0;
            rem = target - beats_sent;
            if (rem > 110 && $urandom_range(3) == 0) n = $urandom_range(6, 10);
            else n = $urandom_range(1, 5);
            kind = $urandom_range(19);
            kind = kind < 15 ? 0 : (kind < 19 ? 1 : 2);
            drain();
            configure(n,
                      $urandom_range(2) == 0 ? $urandom_range(32'h7fff_ffff)
                                             : $urandom_range(0, 2000),
                      n > 8 ? $urandom_range(1, 12) : $urandom_range(1, 40));
            load_system(n, kind);
            send(REQ_START, $urandom_range(15), $urandom_range(15), $urandom);
        end
        drain();

        $display("Run: %0d beats in, %0d solution beats checked, %0d mismatches.",
                 sb.beats_in, sb.results_out, sb.mismatches);
        $display("Solves ended converged %0d, diverged %0d, at limit %0d, zero pivot %0d.",
                 sb.status_seen[0], sb.status_seen[1], sb.status_seen[2],
                 sb.status_seen[3]);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("gauss_seidel_solver regression: pass");
        end else begin
            $display("gauss_seidel_solver regression: fail");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Timed out waiting for the solver.");
        $display("gauss_seidel_solver regression: fail");
        $finish;
    end

endmodule

>>> gauss_seidel_solver.f
rtl/gss_pkg.sv
rtl/gss_ram.sv
rtl/gss_div.sv
rtl/gss_datapath.sv
rtl/gss_ctrl.sv
rtl/gauss_seidel_solver.sv
tb/tb_gauss_seidel_solver.sv
